### rtl/core/lfs_pkg.sv
// Package for the line-following steering controller.
// Holds the sequencer state type, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package lfs_pkg;

  // Q4.12 angle constants.
  localparam logic signed [15:0] Q_PI      = 16'sd12868;
  localparam logic signed [15:0] Q_TWO_PI  = 16'sd25736;
  localparam logic signed [15:0] Q_HALF_PI = 16'sd6434;

  // CORDIC start value: gain compensation 0.60725 in Q2.30.
  localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

  // Largest number of CORDIC rotations that the table supports.
  localparam int unsigned ATAN_LEN = 24;

  // Datapath widths.
  localparam int unsigned CW      = 33;  // CORDIC x, y, z
  localparam int unsigned ACC_W   = 60;  // product accumulator
  localparam int unsigned MPL_W   = 25;  // serial multiplier operand
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 23;

  typedef enum logic [2:0] {
    CFG_CROSS_GAIN   = 3'd0,
    CFG_HEADING_GAIN = 3'd1,
    CFG_RATE_GAIN    = 3'd2,
    CFG_CRUISE_SPEED = 3'd3,
    CFG_MAX_LINEAR   = 3'd4,
    CFG_MAX_ANGULAR  = 3'd5,
    CFG_CROSS_LIMIT  = 3'd6
  } cfg_idx_t;

  // Order of the five serial products.
  typedef enum logic [2:0] {
    PR_COS_DY  = 3'd0,
    PR_SIN_DX  = 3'd1,
    PR_CROSS   = 3'd2,
    PR_HEADING = 3'd3,
    PR_DAMP    = 3'd4
  } prod_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CORDIC,
    S_MUL,
    S_ETA,
    S_RATE
  } state_t;

  // arctan(2^-i) in Q2.30.
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] r;
    unique case (i)
      5'd0:  r = 31'd843314857;
      5'd1:  r = 31'd497837829;
      5'd2:  r = 31'd263043837;
      5'd3:  r = 31'd133525159;
      5'd4:  r = 31'd67021687;
      5'd5:  r = 31'd33543516;
      5'd6:  r = 31'd16775851;
      5'd7:  r = 31'd8388437;
      5'd8:  r = 31'd4194283;
      5'd9:  r = 31'd2097149;
      5'd10: r = 31'd1048576;
      5'd11: r = 31'd524287;
      5'd12: r = 31'd262143;
      5'd13: r = 31'd131071;
      5'd14: r = 31'd65535;
      5'd15: r = 31'd32767;
      5'd16: r = 31'd16383;
      5'd17: r = 31'd8191;
      5'd18: r = 31'd4095;
      5'd19: r = 31'd2047;
      5'd20: r = 31'd1023;
      5'd21: r = 31'd511;
      5'd22: r = 31'd255;
      5'd23: r = 31'd127;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/line_following_steering.sv
// Top level of the line-following steering controller.
// Depends on lfs_pkg for constants, the sequencer state type and the arctangent table.
// Holds the CORDIC unit, the bit-serial multiply-accumulate unit and the config registers.

// One input transaction is one control tick: the pose and the target line go in, one
// transaction with the clamped forward speed and the saturated angular rate comes out.
// The tick runs on a single sequencer. First a rotation-mode CORDIC produces sin and
// cos of the line angle, one rotation per cycle, over min(CORDIC_STEPS, 24) rotations.
// Then a shift-add multiplier that consumes one multiplier bit per cycle forms five
// products of 25 multiplier bits each into one 60-bit accumulator: cos*dy and sin*dx
// for the cross-track error, then the three gain products for the rate. A load step
// starts the tick, and the cross-track error and the rate are each rounded and clipped
// in a step of their own. The result sits in an output register, so the next tick is
// accepted while a result still waits to be taken.
// Configuration is always ready and must only be written while the block is idle.
module line_following_steering #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream, tdata from bit 0: pose_x[24], pose_y[24], heading[15],
  // line_x[24], line_y[24], line_angle[15], 2 zero pad bits.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,
  // Result stream, tdata from bit 0: linear_velocity[16], angular_velocity[16].
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lfs_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lfs_pkg::*;

  localparam int unsigned ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int unsigned CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int unsigned BIT_W = $clog2(MPL_W);

  // Configuration registers.
  logic [15:0]        cross_gain_r, heading_gain_r, rate_gain_r;
  logic signed [15:0] cruise_speed_r;
  logic [14:0]        max_linear_r, max_angular_r;
  logic [22:0]        cross_limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_gain_r   <= 16'd5898;
      heading_gain_r <= 16'd2621;
      rate_gain_r    <= 16'd1966;
      cruise_speed_r <= 16'sd819;
      max_linear_r   <= 15'd2048;
      max_angular_r  <= 15'd4096;
      cross_limit_r  <= 23'd1638;
    end else if (cfg_valid) begin
      // Indexes past the last register are ignored.
      unique case (cfg_index)
        CFG_CROSS_GAIN:   cross_gain_r   <= cfg_data[15:0];
        CFG_HEADING_GAIN: heading_gain_r <= cfg_data[15:0];
        CFG_RATE_GAIN:    rate_gain_r    <= cfg_data[15:0];
        CFG_CRUISE_SPEED: cruise_speed_r <= cfg_data[15:0];
        CFG_MAX_LINEAR:   max_linear_r   <= cfg_data[14:0];
        CFG_MAX_ANGULAR:  max_angular_r  <= cfg_data[14:0];
        CFG_CROSS_LIMIT:  cross_limit_r  <= cfg_data[22:0];
        default: ;
      endcase
    end
  end

  // Input field unpacking.
  logic signed [23:0] pose_x, pose_y, line_x, line_y;
  logic signed [14:0] heading, line_angle;
  assign pose_x     = in_tdata[23:0];
  assign pose_y     = in_tdata[47:24];
  assign heading    = in_tdata[62:48];
  assign line_x     = in_tdata[86:63];
  assign line_y     = in_tdata[110:87];
  assign line_angle = in_tdata[125:111];

  // Angle reduction into [-pi/2, pi/2] with a sign flip, and heading error wrap.
  logic signed [15:0] ang_w, ang_f, phi_raw, phi_wrap;
  logic               flip_in;
  always_comb begin
    ang_w = 16'(line_angle);
    if (ang_w >= Q_PI)        ang_w = ang_w - Q_TWO_PI;
    else if (ang_w < -Q_PI)   ang_w = ang_w + Q_TWO_PI;
    ang_f   = ang_w;
    flip_in = 1'b0;
    if (ang_w > Q_HALF_PI) begin
      ang_f   = ang_w - Q_PI;
      flip_in = 1'b1;
    end else if (ang_w < -Q_HALF_PI) begin
      ang_f   = ang_w + Q_PI;
      flip_in = 1'b1;
    end
    phi_raw  = 16'(heading) - 16'(line_angle);
    phi_wrap = phi_raw;
    if (phi_raw >= Q_PI)      phi_wrap = phi_raw - Q_TWO_PI;
    else if (phi_raw < -Q_PI) phi_wrap = phi_raw + Q_TWO_PI;
  end

  // Datapath and control registers.
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       iter_r, iter_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  prod_t                  prod_r, prod_nxt;
  logic                   flip_r, flip_nxt;
  logic signed [CW-1:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic signed [24:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [15:0]     phi_r, phi_nxt;
  logic signed [23:0]     eta_r, eta_nxt;
  logic signed [15:0]     prev_r, prev_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [MPL_W-1:0]       mpl_r, mpl_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic signed [15:0]     lin_r, lin_nxt, ang_r, ang_nxt;

  // CORDIC rotation step.
  logic signed [CW-1:0] x_sh, y_sh, atan_v;
  assign x_sh   = x_r >>> iter_r;
  assign y_sh   = y_r >>> iter_r;
  assign atan_v = CW'(atan_q30(5'(iter_r)));

  // Cosine and sine after the fold. They are taken from the next rotation value so
  // that the first product, loaded in the last rotation cycle, sees the final step.
  logic signed [CW:0] cos_v, sin_v;
  assign cos_v = flip_r ? -(CW+1)'(x_nxt) : (CW+1)'(x_nxt);
  assign sin_v = flip_r ? -(CW+1)'(y_nxt) : (CW+1)'(y_nxt);

  // Rounding and clipping of the cross-track error and the rate.
  logic signed [29:0] eta_full, lim_e;
  logic signed [43:0] w_full, lim_w;
  logic signed [23:0] eta_clip;
  logic signed [15:0] w_clip, lin_clip, lim_l;
  always_comb begin
    eta_full = acc_r[ACC_W-1:30];
    lim_e    = 30'(cross_limit_r);
    if (eta_full > lim_e)       eta_clip = 24'(lim_e);
    else if (eta_full < -lim_e) eta_clip = 24'(-lim_e);
    else                        eta_clip = 24'(eta_full);
    w_full = acc_r[ACC_W-1:16];
    lim_w  = 44'(max_angular_r);
    if (w_full > lim_w)       w_clip = 16'(lim_w);
    else if (w_full < -lim_w) w_clip = 16'(-lim_w);
    else                      w_clip = 16'(w_full);
    lim_l = 16'(max_linear_r);
    if (cruise_speed_r > lim_l)       lin_clip = lim_l;
    else if (cruise_speed_r < -lim_l) lin_clip = -lim_l;
    else                              lin_clip = cruise_speed_r;
  end

  // Multiplicand and multiplier for the next product.
  logic signed [ACC_W-1:0] op_mcand;
  logic [MPL_W-1:0]        op_mpl;
  always_comb begin
    unique case (prod_nxt)
      PR_COS_DY: begin
        op_mcand = ACC_W'(cos_v);
        op_mpl   = dy_r;
      end
      PR_SIN_DX: begin
        op_mcand = -ACC_W'(sin_v);
        op_mpl   = dx_r;
      end
      PR_CROSS: begin
        op_mcand = -ACC_W'(eta_nxt);
        op_mpl   = MPL_W'(cross_gain_r);
      end
      PR_HEADING: begin
        op_mcand = -ACC_W'(phi_r);
        op_mpl   = MPL_W'(heading_gain_r);
      end
      PR_DAMP: begin
        op_mcand = -ACC_W'(prev_r);
        op_mpl   = MPL_W'(rate_gain_r);
      end
      default: begin
        op_mcand = '0;
        op_mpl   = '0;
      end
    endcase
  end

  logic last_bit;
  assign last_bit = (bit_r == BIT_W'(MPL_W - 1));

  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    bit_nxt       = bit_r;
    prod_nxt      = prod_r;
    flip_nxt      = flip_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    phi_nxt       = phi_r;
    eta_nxt       = eta_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mpl_nxt       = mpl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    lin_nxt       = lin_r;
    ang_nxt       = ang_r;
    in_tready     = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          dx_nxt    = 25'(pose_x) - 25'(line_x);
          dy_nxt    = 25'(pose_y) - 25'(line_y);
          phi_nxt   = phi_wrap;
          flip_nxt  = flip_in;
          x_nxt     = CORDIC_K;
          y_nxt     = '0;
          z_nxt     = CW'(ang_f) <<< 18;
          iter_nxt  = '0;
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (!z_r[CW-1]) begin
          x_nxt = x_r - y_sh;
          y_nxt = y_r + x_sh;
          z_nxt = z_r - atan_v;
        end else begin
          x_nxt = x_r + y_sh;
          y_nxt = y_r - x_sh;
          z_nxt = z_r + atan_v;
        end
        iter_nxt = iter_r + 1'b1;
        if (iter_r == CNT_W'(ITERS - 1)) begin
          prod_nxt  = PR_COS_DY;
          acc_nxt   = ACC_W'(64'sd1 <<< 29);
          bit_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // The top multiplier bit carries negative weight.
        if (mpl_r[0]) acc_nxt = last_bit ? acc_r - mcand_r : acc_r + mcand_r;
        mcand_nxt = mcand_r <<< 1;
        mpl_nxt   = mpl_r >> 1;
        bit_nxt   = bit_r + 1'b1;
        if (last_bit) begin
          bit_nxt = '0;
          unique case (prod_r)
            PR_COS_DY:  prod_nxt = PR_SIN_DX;
            PR_SIN_DX:  state_nxt = S_ETA;
            PR_CROSS:   prod_nxt = PR_HEADING;
            PR_HEADING: prod_nxt = PR_DAMP;
            PR_DAMP:    state_nxt = S_RATE;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ETA: begin
        eta_nxt   = eta_clip;
        prod_nxt  = PR_CROSS;
        acc_nxt   = (ACC_W'(prev_r) <<< 16) + ACC_W'(32768);
        bit_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_RATE: begin
        if (!out_valid_r || out_tready) begin
          prev_nxt      = w_clip;
          ang_nxt       = w_clip;
          lin_nxt       = lin_clip;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Load the operands whenever a new product starts.
    if ((state_r == S_CORDIC && state_nxt == S_MUL) || state_r == S_ETA ||
        (state_r == S_MUL && last_bit && state_nxt == S_MUL)) begin
      mcand_nxt = op_mcand;
      mpl_nxt   = op_mpl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      iter_r      <= '0;
      bit_r       <= '0;
      prod_r      <= PR_COS_DY;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_r      <= prev_nxt;
      iter_r      <= iter_nxt;
      bit_r       <= bit_nxt;
      prod_r      <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flip_r  <= flip_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    z_r     <= z_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    phi_r   <= phi_nxt;
    eta_r   <= eta_nxt;
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    mpl_r   <= mpl_nxt;
    lin_r   <= lin_nxt;
    ang_r   <= ang_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {ang_r, lin_r};

  // An accepted tick always starts with the CORDIC pass.
  a_start_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CORDIC)
    else $error("accepted tick did not start the CORDIC pass");

  // The rotation counter never runs past the last table entry in use.
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CORDIC |-> iter_r <= CNT_W'(ITERS - 1))
    else $error("CORDIC counter out of range");

  // Leaving the rate step always presents a result.
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RATE && state_nxt == S_IDLE |=> out_valid_r)
    else $error("result lost at the end of a tick");

  // After the cross-track error step, the rate products always start with the cross-gain product.
  a_prod_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ETA |=> state_r == S_MUL && prod_r == PR_CROSS)
    else $error("rate products started out of order");

endmodule
